FILE: rtl/core/bstb_pkg.sv
// Package for the brush stamp tile binner: constants, types, controller states.
// No dependencies.
package bstb_pkg;

    localparam int TILE_SIZE = 64;
    localparam int TILE_SHIFT = $clog2(TILE_SIZE);
    localparam int MAX_SPAN = 7;
    localparam int MAX_RES = 8192;
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);

    localparam int RES_W = 14;
    localparam int CTR_W = 20;
    localparam int RAD_W = 16;
    localparam int PIX_W = 18;
    localparam int TILE_W = 7;
    localparam int IDX_W = 16;
    localparam int TCNT_W = RES_W;
    localparam int PROD_W = CTR_W + RES_W + 1;
    localparam int Q_W = PROD_W + 2;
    localparam int TIDX_W = Q_W - 16 - TILE_SHIFT + 1;
    localparam int MODC_W = $clog2(TIDX_W + 1);

    localparam logic [1:0] REG_STROKE = 2'd0;
    localparam logic [1:0] REG_RES_X = 2'd1;
    localparam logic [1:0] REG_RES_Y = 2'd2;

    localparam logic KIND_TILE = 1'b0;
    localparam logic KIND_DIRTY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BOX,
        ST_TILE,
        ST_MOD,
        ST_WALK,
        ST_DIRTY
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic box;
        logic tile;
        logic mod;
        logic step;
        logic emit_tile;
        logic emit_dirty;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last_tile;
        logic mod_done;
    } sts_t;

endpackage

FILE: rtl/core/brush_stamp_tile_binner_unit.sv
// Top level of the brush stamp tile binner: config registers, sample counter,
// controller and datapath. Depends on bstb_pkg, bstb_ctrl, bstb_datapath.
// Sequence: accept, setup states (multiply, pixel box, tile range), start tile
// remainder, then one visited tile per cycle (up to 49) while the output is not
// stalled, and the dirty record; next item taken once the dirty record is issued.
// Reset: asynchronous active low clears config, counter and controller.
module brush_stamp_tile_binner_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [bstb_pkg::RES_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [bstb_pkg::CTR_W-1:0] center_u,
    input  logic signed [bstb_pkg::CTR_W-1:0] center_v,
    input  logic [bstb_pkg::RAD_W-1:0]        radius_uv,
    input  logic                              wrap_mode,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic [bstb_pkg::TILE_W-1:0]       tile_col,
    output logic [bstb_pkg::TILE_W-1:0]       tile_row,
    output logic [bstb_pkg::IDX_W-1:0]        stamp_index,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_min_x,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_min_y,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_max_x,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_max_y,
    output logic                              span_truncated,
    output logic                              last_of_run
);
    import bstb_pkg::*;

    logic stroke_reg;
    logic [RES_W-1:0] resx_reg, resy_reg;
    logic [IDX_W-1:0] count_reg;
    logic active;
    cmd_t cmd;
    sts_t sts;

    assign active = stroke_reg && (resx_reg != '0) && (resy_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stroke_reg <= 1'b0;
            resx_reg <= '0;
            resy_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STROKE:
                    begin
                        stroke_reg <= cfg_data[0];
                        count_reg <= '0;
                    end
                    REG_RES_X: resx_reg <= cfg_data;
                    REG_RES_Y: resy_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load && active && count_reg != '1)
                count_reg <= count_reg + IDX_W'(1);
        end
    end

    bstb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .active    (active),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bstb_datapath u_dp
    (
        .clk            (clk),
        .cmd            (cmd),
        .sts            (sts),
        .center_u       (center_u),
        .center_v       (center_v),
        .radius_uv      (radius_uv),
        .wrap_mode      (wrap_mode),
        .res_x          (resx_reg),
        .res_y          (resy_reg),
        .index_in       (count_reg),
        .result_kind    (result_kind),
        .tile_col       (tile_col),
        .tile_row       (tile_row),
        .stamp_index    (stamp_index),
        .dirty_min_x    (dirty_min_x),
        .dirty_min_y    (dirty_min_y),
        .dirty_max_x    (dirty_max_x),
        .dirty_max_y    (dirty_max_y),
        .span_truncated (span_truncated),
        .last_of_run    (last_of_run)
    );

endmodule

FILE: rtl/core/bstb_datapath.sv
// Datapath: scaling multiplies, pixel box, tile range, start-tile remainder,
// tile walk, output records. Depends on bstb_pkg.
module bstb_datapath
(
    input  logic                              clk,
    input  bstb_pkg::cmd_t                    cmd,
    output bstb_pkg::sts_t                    sts,
    input  logic signed [bstb_pkg::CTR_W-1:0] center_u,
    input  logic signed [bstb_pkg::CTR_W-1:0] center_v,
    input  logic [bstb_pkg::RAD_W-1:0]        radius_uv,
    input  logic                              wrap_mode,
    input  logic [bstb_pkg::RES_W-1:0]        res_x,
    input  logic [bstb_pkg::RES_W-1:0]        res_y,
    input  logic [bstb_pkg::IDX_W-1:0]        index_in,
    output logic                              result_kind,
    output logic [bstb_pkg::TILE_W-1:0]       tile_col,
    output logic [bstb_pkg::TILE_W-1:0]       tile_row,
    output logic [bstb_pkg::IDX_W-1:0]        stamp_index,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_min_x,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_min_y,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_max_x,
    output logic signed [bstb_pkg::PIX_W-1:0] dirty_max_y,
    output logic                              span_truncated,
    output logic                              last_of_run
);
    import bstb_pkg::*;

    logic signed [CTR_W-1:0] cu_reg, cv_reg;
    logic [RAD_W-1:0] rad_reg;
    logic wrap_reg;
    logic [RES_W-1:0] rx_reg, ry_reg;
    logic [IDX_W-1:0] idx_reg;
    logic signed [PROD_W-1:0] cx_reg, cy_reg, rpx_reg, rpy_reg;
    logic signed [Q_W-17:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [TIDX_W-1:0] tx0_reg, tx_reg, ty_reg;
    logic [SPAN_W-1:0] cntx_reg, cnty_reg, cntx0_reg;
    logic trunc_reg;
    logic [TCNT_W-1:0] tcx_reg, tcy_reg;

    logic [RES_W-1:0] rxc, ryc;
    logic signed [PROD_W-1:0] rpx_c, rpy_c;
    logic signed [Q_W-1:0] lox, hix, loy, hiy;
    logic signed [Q_W-17:0] minx_c, maxx_c, miny_c, maxy_c;
    logic signed [TIDX_W-1:0] mtx, xtx, mty, xty;
    logic signed [TIDX_W:0] spx, spy;
    logic truncx, truncy;
    logic in_x, in_y;

    logic [TIDX_W-1:0] dvx_reg, dvy_reg;
    logic [TCNT_W-1:0] remx_reg, remy_reg;
    logic [TCNT_W-1:0] remx_next, remy_next;
    logic [TCNT_W:0] shx, shy;
    logic negx_reg, negy_reg;
    logic [MODC_W-1:0] modc_reg;

    localparam logic signed [PROD_W-1:0] ONE = PROD_W'(65536);

    assign rxc = (res_x > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : res_x;
    assign ryc = (res_y > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : res_y;
    assign rpx_c = (rpx_reg < ONE) ? ONE : rpx_reg;
    assign rpy_c = (rpy_reg < ONE) ? ONE : rpy_reg;
    assign lox = Q_W'(cx_reg) - Q_W'(rpx_c) - Q_W'(ONE);
    assign hix = Q_W'(cx_reg) + Q_W'(rpx_c) + Q_W'(ONE) + Q_W'(65535);
    assign loy = Q_W'(cy_reg) - Q_W'(rpy_c) - Q_W'(ONE);
    assign hiy = Q_W'(cy_reg) + Q_W'(rpy_c) + Q_W'(ONE) + Q_W'(65535);
    assign minx_c = lox[Q_W-1:16];
    assign maxx_c = hix[Q_W-1:16];
    assign miny_c = loy[Q_W-1:16];
    assign maxy_c = hiy[Q_W-1:16];

    assign mtx = TIDX_W'(minx_reg >>> TILE_SHIFT);
    assign xtx = TIDX_W'(maxx_reg >>> TILE_SHIFT);
    assign mty = TIDX_W'(miny_reg >>> TILE_SHIFT);
    assign xty = TIDX_W'(maxy_reg >>> TILE_SHIFT);
    assign spx = (TIDX_W+1)'(xtx) - (TIDX_W+1)'(mtx);
    assign spy = (TIDX_W+1)'(xty) - (TIDX_W+1)'(mty);
    assign truncx = spx > (TIDX_W+1)'(MAX_SPAN - 1);
    assign truncy = spy > (TIDX_W+1)'(MAX_SPAN - 1);

    // wrap by one compare step per tile move; start index wrapped by the remainder unit
    assign in_x = (tx_reg >= 0) && ((TIDX_W+2)'(tx_reg) < (TIDX_W+2)'($signed({1'b0, tcx_reg})));
    assign in_y = (ty_reg >= 0) && ((TIDX_W+2)'(ty_reg) < (TIDX_W+2)'($signed({1'b0, tcy_reg})));
    assign sts.hit = wrap_reg || (in_x && in_y);
    assign sts.last_tile = (cntx_reg == SPAN_W'(1)) && (cnty_reg == SPAN_W'(1));
    assign sts.mod_done = (modc_reg == '0);

    logic [TCNT_W-1:0] wx0, wy0;
    logic [TCNT_W-1:0] colw_reg, roww_reg, colw0_reg;
    logic signed [PIX_W+1:0] dx0, dy0, dx1, dy1;

    // restoring remainder of the start tile magnitude, one dividend bit per cycle
    assign shx = {remx_reg, dvx_reg[TIDX_W-1]};
    assign shy = {remy_reg, dvy_reg[TIDX_W-1]};
    assign remx_next = (shx >= {1'b0, tcx_reg}) ? TCNT_W'(shx - {1'b0, tcx_reg}) : TCNT_W'(shx);
    assign remy_next = (shy >= {1'b0, tcy_reg}) ? TCNT_W'(shy - {1'b0, tcy_reg}) : TCNT_W'(shy);
    assign wx0 = (negx_reg && (remx_reg != '0)) ? tcx_reg - remx_reg : remx_reg;
    assign wy0 = (negy_reg && (remy_reg != '0)) ? tcy_reg - remy_reg : remy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cu_reg <= center_u;
            cv_reg <= center_v;
            rad_reg <= radius_uv;
            wrap_reg <= wrap_mode;
            rx_reg <= rxc;
            ry_reg <= ryc;
            idx_reg <= index_in;
        end
        if (cmd.mul)
        begin
            cx_reg <= PROD_W'(cu_reg) * $signed({1'b0, rx_reg});
            cy_reg <= PROD_W'(cv_reg) * $signed({1'b0, ry_reg});
            rpx_reg <= $signed(PROD_W'(rad_reg)) * $signed({1'b0, rx_reg});
            rpy_reg <= $signed(PROD_W'(rad_reg)) * $signed({1'b0, ry_reg});
            tcx_reg <= TCNT_W'((rx_reg + RES_W'(TILE_SIZE - 1)) >> TILE_SHIFT);
            tcy_reg <= TCNT_W'((ry_reg + RES_W'(TILE_SIZE - 1)) >> TILE_SHIFT);
        end
        if (cmd.box)
        begin
            minx_reg <= minx_c;
            maxx_reg <= maxx_c;
            miny_reg <= miny_c;
            maxy_reg <= maxy_c;
        end
        if (cmd.tile)
        begin
            tx0_reg <= mtx;
            tx_reg <= mtx;
            ty_reg <= mty;
            cntx_reg <= truncx ? SPAN_W'(MAX_SPAN) : SPAN_W'(spx + 1);
            cnty_reg <= truncy ? SPAN_W'(MAX_SPAN) : SPAN_W'(spy + 1);
            cntx0_reg <= truncx ? SPAN_W'(MAX_SPAN) : SPAN_W'(spx + 1);
            trunc_reg <= truncx || truncy;
            negx_reg <= mtx[TIDX_W-1];
            negy_reg <= mty[TIDX_W-1];
            dvx_reg <= mtx[TIDX_W-1] ? TIDX_W'(-mtx) : TIDX_W'(mtx);
            dvy_reg <= mty[TIDX_W-1] ? TIDX_W'(-mty) : TIDX_W'(mty);
            remx_reg <= '0;
            remy_reg <= '0;
            modc_reg <= MODC_W'(TIDX_W);
        end
        else if (cmd.mod)
        begin
            if (modc_reg == '0)
            begin
                colw0_reg <= wx0;
                colw_reg <= wx0;
                roww_reg <= wy0;
            end
            else
            begin
                remx_reg <= remx_next;
                remy_reg <= remy_next;
                dvx_reg <= dvx_reg << 1;
                dvy_reg <= dvy_reg << 1;
                modc_reg <= modc_reg - MODC_W'(1);
            end
        end
        else if (cmd.step)
        begin
            if (cntx_reg == SPAN_W'(1))
            begin
                tx_reg <= tx0_reg;
                cntx_reg <= cntx0_reg;
                colw_reg <= colw0_reg;
                ty_reg <= ty_reg + TIDX_W'(1);
                cnty_reg <= cnty_reg - SPAN_W'(1);
                roww_reg <= (roww_reg + TCNT_W'(1) == tcy_reg) ? '0 : roww_reg + TCNT_W'(1);
            end
            else
            begin
                tx_reg <= tx_reg + TIDX_W'(1);
                cntx_reg <= cntx_reg - SPAN_W'(1);
                colw_reg <= (colw_reg + TCNT_W'(1) == tcx_reg) ? '0 : colw_reg + TCNT_W'(1);
            end
        end
    end

    always_comb
    begin
        dx0 = (PIX_W+2)'(minx_reg);
        dy0 = (PIX_W+2)'(miny_reg);
        dx1 = (PIX_W+2)'(maxx_reg) + (PIX_W+2)'(1);
        dy1 = (PIX_W+2)'(maxy_reg) + (PIX_W+2)'(1);
        if (!wrap_reg)
        begin
            dx0 = (dx0 < 0) ? '0 : ((dx0 > $signed((PIX_W+2)'(rx_reg))) ? (PIX_W+2)'(rx_reg) : dx0);
            dy0 = (dy0 < 0) ? '0 : ((dy0 > $signed((PIX_W+2)'(ry_reg))) ? (PIX_W+2)'(ry_reg) : dy0);
            dx1 = (dx1 < 0) ? '0 : ((dx1 > $signed((PIX_W+2)'(rx_reg))) ? (PIX_W+2)'(rx_reg) : dx1);
            dy1 = (dy1 < 0) ? '0 : ((dy1 > $signed((PIX_W+2)'(ry_reg))) ? (PIX_W+2)'(ry_reg) : dy1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_tile || cmd.emit_dirty)
        begin
            result_kind <= cmd.emit_dirty ? KIND_DIRTY : KIND_TILE;
            stamp_index <= idx_reg;
            span_truncated <= trunc_reg;
            last_of_run <= cmd.emit_dirty;
            tile_col <= cmd.emit_dirty ? '0
                      : (wrap_reg ? TILE_W'(colw_reg) : TILE_W'(tx_reg));
            tile_row <= cmd.emit_dirty ? '0
                      : (wrap_reg ? TILE_W'(roww_reg) : TILE_W'(ty_reg));
            dirty_min_x <= cmd.emit_dirty ? PIX_W'(dx0) : '0;
            dirty_min_y <= cmd.emit_dirty ? PIX_W'(dy0) : '0;
            dirty_max_x <= cmd.emit_dirty ? PIX_W'(dx1) : '0;
            dirty_max_y <= cmd.emit_dirty ? PIX_W'(dy1) : '0;
        end
    end

endmodule

FILE: rtl/core/bstb_ctrl.sv
// Controller state machine: sequences setup, tile walk and dirty record.
// Depends on bstb_pkg.
module bstb_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           active,
    output logic           out_valid,
    input  logic           out_stall,
    output bstb_pkg::cmd_t cmd,
    input  bstb_pkg::sts_t sts
);
    import bstb_pkg::*;

    state_t state_reg, state_next;
    logic ov_reg, ov_next;
    logic free;

    assign free = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && active) state_next = ST_MUL;
            ST_MUL:   state_next = ST_BOX;
            ST_BOX:   state_next = ST_TILE;
            ST_TILE:  state_next = ST_MOD;
            ST_MOD:   if (sts.mod_done) state_next = ST_WALK;
            ST_WALK:
                if (free && sts.last_tile)
                    state_next = ST_DIRTY;
            ST_DIRTY: if (free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        ov_next = ov_reg && out_stall;
        case (state_reg)
            ST_IDLE:  cmd.load = in_valid;
            ST_MUL:   cmd.mul = 1'b1;
            ST_BOX:   cmd.box = 1'b1;
            ST_TILE:  cmd.tile = 1'b1;
            ST_MOD:   cmd.mod = 1'b1;
            ST_WALK:
                if (free)
                begin
                    cmd.step = 1'b1;
                    cmd.emit_tile = sts.hit;
                    ov_next = sts.hit;
                end
            ST_DIRTY:
                if (free)
                begin
                    cmd.emit_dirty = 1'b1;
                    ov_next = 1'b1;
                end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg)
        else $error("item dropped under stall");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_tile || cmd.emit_dirty) |-> free)
        else $error("emit while output busy");
    a_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIRTY && free |=> state_reg == ST_IDLE && ov_reg)
        else $error("dirty record missing");
`endif

endmodule

FILE: verif/tb_brush_stamp_tile_binner_unit.sv
// Self-checking testbench for brush_stamp_tile_binner_unit: directed table, random
// phases with sender/receiver idling and a pause that drains all pending records.
// Depends on bstb_pkg and the RTL of the block.
module tb_brush_stamp_tile_binner_unit;
    import bstb_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int DRAIN_CYCLES = 80;
    localparam int QUIET_LIMIT = 6000;
    localparam longint ONE = 65536;

    typedef enum logic { OP_CFG, OP_ITEM } op_t;

    typedef struct {
        logic                    kind;
        logic [TILE_W-1:0]       col;
        logic [TILE_W-1:0]       row;
        logic [IDX_W-1:0]        idx;
        logic signed [PIX_W-1:0] x0;
        logic signed [PIX_W-1:0] y0;
        logic signed [PIX_W-1:0] x1;
        logic signed [PIX_W-1:0] y1;
        logic                    trunc;
        logic                    last;
    } record_t;

    typedef struct {
        op_t    op;
        int     a;
        int     b;
        int     c;
        int     d;
        bit     chk;
        int     n;
        int     x0;
        int     y0;
        int     x1;
        int     y1;
    } row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [1:0]               cfg_index;
    logic [RES_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [CTR_W-1:0]  center_u;
    logic signed [CTR_W-1:0]  center_v;
    logic [RAD_W-1:0]         radius_uv;
    logic                     wrap_mode;
    logic                     out_valid;
    logic                     out_stall;
    logic                     result_kind;
    logic [TILE_W-1:0]        tile_col;
    logic [TILE_W-1:0]        tile_row;
    logic [IDX_W-1:0]         stamp_index;
    logic signed [PIX_W-1:0]  dirty_min_x;
    logic signed [PIX_W-1:0]  dirty_min_y;
    logic signed [PIX_W-1:0]  dirty_max_x;
    logic signed [PIX_W-1:0]  dirty_max_y;
    logic                     span_truncated;
    logic                     last_of_run;

    record_t          expected_records[$];
    logic             stroke_open;
    logic [RES_W-1:0] res_x;
    logic [RES_W-1:0] res_y;
    logic [IDX_W-1:0] stamp_count;
    int               pct_in;
    int               pct_out;
    int               errors;
    int               quiet_cycles;
    int               records_seen;
    int               samples_sent;

    brush_stamp_tile_binner_unit dut (.*);

    always #HALF_PERIOD clk = ~clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic longint floor_div(input longint v, input longint d);
        if (v >= 0)
            return v / d;
        return -(((-v) + d - 1) / d);
    endfunction

    function automatic longint wrap_mod(input longint v, input longint d);
        return ((v % d) + d) % d;
    endfunction

    function automatic longint clip(input longint v, input longint hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic int bin_sample(input logic signed [CTR_W-1:0] u,
                                      input logic signed [CTR_W-1:0] v,
                                      input logic [RAD_W-1:0] r, input logic w);
        longint rx, ry, cx, cy, rpx, rpy, minx, maxx, miny, maxy;
        longint tcx, tcy, mtx, xtx, mty, xty;
        logic trunc;
        logic [IDX_W-1:0] idx;
        record_t rec;
        record_t hits[$];
        if (!stroke_open || res_x == 0 || res_y == 0)
            return 0;
        rx = res_x > MAX_RES ? longint'(MAX_RES) : longint'(res_x);
        ry = res_y > MAX_RES ? longint'(MAX_RES) : longint'(res_y);
        idx = stamp_count;
        if (stamp_count != 16'hFFFF)
            stamp_count++;
        cx = longint'(u) * rx;
        cy = longint'(v) * ry;
        rpx = longint'(r) * rx;
        rpy = longint'(r) * ry;
        if (rpx < ONE) rpx = ONE;
        if (rpy < ONE) rpy = ONE;
        minx = floor_div(cx - rpx - ONE, ONE);
        maxx = -floor_div(-(cx + rpx + ONE), ONE);
        miny = floor_div(cy - rpy - ONE, ONE);
        maxy = -floor_div(-(cy + rpy + ONE), ONE);
        tcx = (rx + TILE_SIZE - 1) / TILE_SIZE;
        tcy = (ry + TILE_SIZE - 1) / TILE_SIZE;
        mtx = floor_div(minx, TILE_SIZE);
        xtx = floor_div(maxx, TILE_SIZE);
        mty = floor_div(miny, TILE_SIZE);
        xty = floor_div(maxy, TILE_SIZE);
        trunc = 1'b0;
        if (xtx - mtx + 1 > MAX_SPAN)
        begin
            xtx = mtx + MAX_SPAN - 1;
            trunc = 1'b1;
        end
        if (xty - mty + 1 > MAX_SPAN)
        begin
            xty = mty + MAX_SPAN - 1;
            trunc = 1'b1;
        end
        for (longint ty = mty; ty <= xty; ty++)
        begin
            if (!w && (ty < 0 || ty >= tcy))
                continue;
            for (longint tx = mtx; tx <= xtx; tx++)
            begin
                if (!w && (tx < 0 || tx >= tcx))
                    continue;
                rec = '{KIND_TILE, 0, 0, idx, 0, 0, 0, 0, 1'b0, 1'b0};
                rec.col = TILE_W'(w ? wrap_mod(tx, tcx) : tx);
                rec.row = TILE_W'(w ? wrap_mod(ty, tcy) : ty);
                hits.push_back(rec);
            end
        end
        rec = '{KIND_DIRTY, 0, 0, idx, 0, 0, 0, 0, 1'b0, 1'b1};
        rec.x0 = PIX_W'(w ? minx : clip(minx, rx));
        rec.y0 = PIX_W'(w ? miny : clip(miny, ry));
        rec.x1 = PIX_W'(w ? maxx + 1 : clip(maxx + 1, rx));
        rec.y1 = PIX_W'(w ? maxy + 1 : clip(maxy + 1, ry));
        hits.push_back(rec);
        foreach (hits[i])
        begin
            hits[i].trunc = trunc;
            expected_records.push_back(hits[i]);
        end
        return hits.size();
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input int value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= RES_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_STROKE:
            begin
                stroke_open = value[0];
                stamp_count = '0;
            end
            REG_RES_X: res_x = RES_W'(value);
            REG_RES_Y: res_y = RES_W'(value);
            default: ;
        endcase
    endtask

    task automatic send_sample(input int u, input int v, input int r, input int w,
                               output int n);
        while ($urandom_range(99) < pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        center_u <= CTR_W'(u);
        center_v <= CTR_W'(v);
        radius_uv <= RAD_W'(r);
        wrap_mode <= w[0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = bin_sample(CTR_W'(u), CTR_W'(v), RAD_W'(r), w[0]);
        samples_sent++;
    endtask

    task automatic random_sample(output int u, output int v, output int r, output int w);
        w = $urandom_range(1);
        if ($urandom_range(9) == 0)
        begin
            u = $urandom;
            v = $urandom;
            r = $urandom;
        end
        else
        begin
            u = $urandom_range(90000) - 12000;
            v = $urandom_range(90000) - 12000;
            r = $urandom_range(3) == 0 ? $urandom_range(16000) : $urandom_range(1500);
        end
    endtask

    function automatic int pick_res();
        case ($urandom_range(6))
            0: return 1;
            1: return 64;
            2: return 65;
            3: return 8192;
            4: return 16383;
            default: return $urandom_range(16383, 1);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        record_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            records_seen++;
            if (expected_records.size() == 0)
                report("record with nothing expected");
            else
            begin
                e = expected_records.pop_front();
                if (result_kind !== e.kind) report("result_kind");
                if (tile_col !== e.col) report($sformatf("tile_col %0d exp %0d", tile_col, e.col));
                if (tile_row !== e.row) report($sformatf("tile_row %0d exp %0d", tile_row, e.row));
                if (stamp_index !== e.idx) report($sformatf("stamp_index %0d exp %0d",
                                                             stamp_index, e.idx));
                if (dirty_min_x !== e.x0) report($sformatf("dirty_min_x %0d exp %0d",
                                                            dirty_min_x, e.x0));
                if (dirty_min_y !== e.y0) report($sformatf("dirty_min_y %0d exp %0d",
                                                            dirty_min_y, e.y0));
                if (dirty_max_x !== e.x1) report($sformatf("dirty_max_x %0d exp %0d",
                                                            dirty_max_x, e.x1));
                if (dirty_max_y !== e.y1) report($sformatf("dirty_max_y %0d exp %0d",
                                                            dirty_max_y, e.y1));
                if (span_truncated !== e.trunc) report("span_truncated");
                if (last_of_run !== e.last) report("last_of_run");
            end
        end
        out_stall <= ($urandom_range(99) < pct_out);
    end

    initial
    begin
        row_t plan[$];
        int u, v, r, w, n;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STROKE;
        cfg_data = '0;
        in_valid = 1'b0;
        center_u = '0;
        center_v = '0;
        radius_uv = '0;
        wrap_mode = 1'b0;
        out_stall = 1'b0;
        stroke_open = 1'b0;
        res_x = '0;
        res_y = '0;
        stamp_count = '0;
        pct_in = 0;
        pct_out = 0;
        errors = 0;
        quiet_cycles = 0;
        records_seen = 0;
        samples_sent = 0;

        plan = '{
            '{OP_ITEM, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_STROKE, 1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_RES_X, 64, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_RES_Y, 64, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 0, 0, 0, 0, 1, 2, 0, 0, 3, 3},
            '{OP_ITEM, 0, 0, 0, 1, 1, 5, -2, -2, 3, 3},
            '{OP_ITEM, 524287, 524287, 0, 0, 1, 1, 64, 64, 64, 64},
            '{OP_ITEM, -524288, -524288, 0, 0, 1, 1, 0, 0, 0, 0},
            '{OP_ITEM, 524287, -524288, 65535, 1, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, -524288, 524287, 65535, 0, 0, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_RES_X, 16383, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_RES_Y, 8192, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 32768, 32768, 65535, 1, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 32768, 32768, 65535, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 65535, 0, 300, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, -1, 65536, 300, 1, 0, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_RES_X, 1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_RES_Y, 1, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 32768, 32768, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 32768, 32768, 65535, 1, 0, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_STROKE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OP_ITEM, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
            '{OP_CFG, REG_STROKE, 1, 0, 0, 0, 0, 0, 0, 0, 0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == OP_CFG)
                write_reg(2'(plan[i].a), plan[i].b);
            else
            begin
                send_sample(plan[i].a, plan[i].b, plan[i].c, plan[i].d, n);
                if (plan[i].chk && n != plan[i].n)
                    report($sformatf("table row %0d: %0d records, typed %0d", i, n, plan[i].n));
                else if (plan[i].chk && n != 0 &&
                         (expected_records[$].x0 != plan[i].x0 ||
                          expected_records[$].y0 != plan[i].y0 ||
                          expected_records[$].x1 != plan[i].x1 ||
                          expected_records[$].y1 != plan[i].y1))
                    report($sformatf("table row %0d: dirty rectangle differs from typed", i));
            end
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            pct_in = (phase % 4 == 1) ? 72 : (phase % 4 == 3) ? 21 : 0;
            pct_out = (phase % 4 == 2) ? 72 : (phase % 4 == 3) ? 21 : 0;
            write_reg(REG_RES_X, pick_res());
            write_reg(REG_RES_Y, pick_res());
            write_reg(REG_STROKE, 1);
            for (int k = 0; k < 48; k++)
            begin
                if (k == 20)
                    wait_drained();
                random_sample(u, v, r, w);
                send_sample(u, v, r, w, n);
            end
        end

        pct_in = 0;
        pct_out = 0;
        wait_idle();
        $display("covered %0d samples, %0d records: table, six random phases with idling",
                 samples_sent, records_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/bstb_pkg.sv
rtl/core/bstb_datapath.sv
rtl/core/bstb_ctrl.sv
rtl/core/brush_stamp_tile_binner_unit.sv
verif/tb_brush_stamp_tile_binner_unit.sv
